### design/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg: shared types and codes of the min tracking stack
// Request and response payloads, command and status codes.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned FILL_W = 7;

   localparam logic signed [WORD_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_PEEK = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]               command;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] top_value;
      logic signed [WORD_W-1:0] min_value;
      logic [FILL_W-1:0]        fill_count;
      logic [1:0]               status;
   } rsp_type;

endpackage

### design/min_tracking_stack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_unit: LIFO stack of signed words with running minimum
// Value stack plus a stack of running minima, both in block memories.
// ----------------------------------------------------------------------------
// Every request (push, pop or peek) yields exactly one response carrying the
// top value, the current minimum (both 0 when empty), the fill count and a
// status. Push, peek and refused requests respond in the cycle after they are
// accepted; a successful pop responds later, as the new top and the new
// minimum come out of the synchronous memories through registered reads. One
// request is in flight at a time; a new request is taken in the cycle that
// the previous response is delivered, so without receiver stalls the rate is
// one request per cycle for pushes and peeks, and a pop holds off the next
// request until its memory read is done. The tops of both stacks are cached
// in registers; the memories hold the rest and need no clearing after reset.
// ----------------------------------------------------------------------------
module min_tracking_stack_unit #(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mts_pkg::rsp_type rsp_data
);

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] ONE = CW'(1);
   localparam logic [CW-1:0] TWO = CW'(2);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   // control state
   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    mcount_ff, mcount_in;
   logic             pop_min_ff, pop_min_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // cached top entries and the response register
   logic signed [mts_pkg::WORD_W-1:0] top_ff, top_in;
   logic signed [mts_pkg::WORD_W-1:0] min_ff, min_in;
   mts_pkg::rsp_type                  rsp_ff, rsp_in;

   // memory ports
   logic                              vwr_en, mwr_en;
   logic [AW-1:0]                     vwr_addr, mwr_addr, vrd_addr, mrd_addr;
   logic [mts_pkg::WORD_W-1:0]        vrd_data, mrd_data;

   logic accept;
   logic rsp_take;
   logic [CW-1:0] count_dec2, mcount_dec2;

   // Take a request only when idle and the response slot is free or draining.
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // A pop reads the entries just below the current tops.
   assign count_dec2  = count_ff - TWO;
   assign mcount_dec2 = mcount_ff - TWO;
   assign vrd_addr    = count_dec2[AW-1:0];
   assign mrd_addr    = mcount_dec2[AW-1:0];
   assign vwr_addr    = count_ff[AW-1:0];
   assign mwr_addr    = mcount_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mcount_in    = mcount_ff;
      pop_min_in   = pop_min_ff;
      top_in       = top_ff;
      min_in       = min_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      vwr_en       = 1'b0;
      mwr_en       = 1'b0;

      // default response: unchanged stack
      rsp_in.top_value  = (count_ff != '0) ? top_ff : '0;
      rsp_in.min_value  = (count_ff != '0) ? min_ff : '0;
      rsp_in.fill_count = mts_pkg::FILL_W'(count_ff);
      rsp_in.status     = mts_pkg::STATUS_DONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.command)
                  mts_pkg::CMD_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        rsp_in.status = mts_pkg::STATUS_FULL;
                     end else begin
                        vwr_en   = 1'b1;
                        count_in = count_ff + ONE;
                        top_in   = req_data.value;
                        // at or below the minimum: also onto the minima stack
                        if (count_ff == '0 || req_data.value <= min_ff) begin
                           mwr_en    = 1'b1;
                           mcount_in = mcount_ff + ONE;
                           min_in    = req_data.value;
                        end
                        rsp_in.top_value  = req_data.value;
                        rsp_in.min_value  = min_in;
                        rsp_in.fill_count = mts_pkg::FILL_W'(count_in);
                     end
                  end
                  mts_pkg::CMD_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = mts_pkg::STATUS_EMPTY;
                     end else begin
                        // drop the top; wait for the memory to show the new one
                        count_in   = count_ff - ONE;
                        pop_min_in = (top_ff == min_ff) && (mcount_ff != '0);
                        if (pop_min_in) begin
                           mcount_in = mcount_ff - ONE;
                        end
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     // peek and the unused code leave the stack alone
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (count_ff == '0) begin
               mcount_in = '0;
               min_in    = mts_pkg::INT_MAX;
            end else begin
               top_in = vrd_data;
               if (pop_min_ff) begin
                  min_in = (mcount_ff == '0) ? mts_pkg::INT_MAX : $signed(mrd_data);
               end
            end
            rsp_in.top_value  = (count_ff != '0) ? top_in : '0;
            rsp_in.min_value  = (count_ff != '0) ? min_in : '0;
            rsp_in.fill_count = mts_pkg::FILL_W'(count_ff);
            rsp_in.status     = mts_pkg::STATUS_DONE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hold the response while it waits
      if (rsp_valid_ff && rsp_stall) begin
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mcount_ff    <= '0;
         pop_min_ff   <= 1'b0;
         min_ff       <= mts_pkg::INT_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mcount_ff    <= mcount_in;
         pop_min_ff   <= pop_min_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   mts_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (mts_pkg::WORD_W)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (vwr_en),
      .wr_addr (vwr_addr),
      .wr_data (req_data.value),
      .rd_addr (vrd_addr),
      .rd_data (vrd_data)
   );

   mts_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (mts_pkg::WORD_W)
   ) u_minima_ram (
      .clock   (clock),
      .wr_en   (mwr_en),
      .wr_addr (mwr_addr),
      .wr_data (req_data.value),
      .rd_addr (mrd_addr),
      .rd_data (mrd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/mts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ram: simple dual-port stack memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mts_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_checker: port-level checks of the min tracking stack
// Response consistency and stall behavior, bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker #(
   parameter int unsigned STACK_DEPTH = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input mts_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mts_pkg::rsp_type rsp_data
);

   // a stalled request holds
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // a refused push reports a full stack
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == mts_pkg::STATUS_FULL
      |-> rsp_data.fill_count == mts_pkg::FILL_W'(STACK_DEPTH))
      else $error("refused push without full stack");

   // a refused pop reports an empty stack
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == mts_pkg::STATUS_EMPTY
      |-> rsp_data.fill_count == '0 && rsp_data.top_value == '0
          && rsp_data.min_value == '0)
      else $error("refused pop with nonempty result");

   // the minimum never exceeds the top
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fill_count != '0
      |-> rsp_data.min_value <= rsp_data.top_value)
      else $error("minimum above top value");

endmodule

bind min_tracking_stack_unit mts_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_mts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### test/min_tracking_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_checker: response predictor and comparator
// Watches both channels of the min tracking stack. It keeps its own copy of
// the value and minima stacks and predicts one response per request. It
// then compares every delivered response, field by field, in order.
// ----------------------------------------------------------------------------
module min_tracking_stack_checker #(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  mts_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  mts_pkg::rsp_type rsp_data,
   output int               failures,
   output int               outstanding
);
   import mts_pkg::*;

   localparam int unsigned CHECK_W = WORD_W + 1;

   logic signed [WORD_W-1:0] value_stack  [STACK_DEPTH];
   logic signed [WORD_W-1:0] minima_stack [STACK_DEPTH];
   int unsigned              value_depth;
   int unsigned              minima_depth;
   logic signed [WORD_W-1:0] running_min;

   rsp_type predicted_snapshots [$];
   int      mismatch_count = 0;

   assign failures = mismatch_count;

   // Apply one request to the shadow stacks and return the snapshot it gives.
   function automatic rsp_type apply_stack_command(req_type request);
      rsp_type                  snapshot;
      logic signed [WORD_W-1:0] popped;
      logic                     was_empty;
      snapshot = '0;
      snapshot.status = STATUS_DONE;
      case (request.command)
         CMD_PUSH: begin
            if (value_depth >= STACK_DEPTH) begin
               snapshot.status = STATUS_FULL;
            end else begin
               was_empty = (value_depth == 0);
               value_stack[value_depth] = request.value;
               value_depth++;
               if ((was_empty || request.value <= running_min) &&
                   minima_depth < STACK_DEPTH) begin
                  minima_stack[minima_depth] = request.value;
                  minima_depth++;
                  running_min = request.value;
               end
            end
         end
         CMD_POP: begin
            if (value_depth == 0) begin
               snapshot.status = STATUS_EMPTY;
            end else begin
               popped = value_stack[value_depth-1];
               value_depth--;
               if (minima_depth > 0 && popped == minima_stack[minima_depth-1]) begin
                  minima_depth--;
                  if (value_depth == 0 || minima_depth == 0)
                     running_min = INT_MAX;
                  else
                     running_min = minima_stack[minima_depth-1];
               end
               if (value_depth == 0) begin
                  minima_depth = 0;
                  running_min  = INT_MAX;
               end
            end
         end
         default: begin
            // peek and the unused code leave the stacks alone
         end
      endcase
      if (value_depth > 0) begin
         snapshot.top_value = value_stack[value_depth-1];
         snapshot.min_value = (minima_depth > 0) ? minima_stack[minima_depth-1] : '0;
      end
      snapshot.fill_count = FILL_W'(value_depth);
      return snapshot;
   endfunction

   task automatic check_field(input string field, input logic signed [CHECK_W-1:0] expected,
                              input logic signed [CHECK_W-1:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field,
                  expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type expected;
      rsp_type predicted;
      if (reset) begin
         value_depth  = 0;
         minima_depth = 0;
         running_min  = INT_MAX;
         predicted_snapshots.delete();
      end else begin
         // a response always trails its request, so retire before adding
         if (rsp_valid && !rsp_stall) begin
            if (predicted_snapshots.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %p", $time,
                        rsp_data);
               mismatch_count++;
            end else begin
               expected = predicted_snapshots.pop_front();
               check_field("top_value", CHECK_W'(expected.top_value),
                           CHECK_W'(rsp_data.top_value));
               check_field("min_value", CHECK_W'(expected.min_value),
                           CHECK_W'(rsp_data.min_value));
               check_field("fill_count", CHECK_W'(expected.fill_count),
                           CHECK_W'(rsp_data.fill_count));
               check_field("status", CHECK_W'(expected.status),
                           CHECK_W'(rsp_data.status));
            end
         end
         if (req_valid && !req_stall) begin
            predicted = apply_stack_command(req_data);
            predicted_snapshots = {predicted_snapshots, predicted};
         end
      end
      outstanding <= predicted_snapshots.size();
   end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the min tracking stack
// Drives directed and random push, pop and peek requests through phases of
// sender idling and receiver stalling; the checker beside the block predicts
// and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import mts_pkg::*;

   localparam int unsigned STACK_DEPTH = 64;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES = 10;

   // The command field is two bits wide; the top code has no name in the
   // package and must behave as a peek.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [WORD_W-1:0] INT_MIN = 32'sh8000_0000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int failures;
   int outstanding;

   int unsigned cycle_count = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned stall_pct = 0;
   logic        hold_request = 1'b0;
   logic        hold_taken = 1'b0;
   int unsigned hold_left = 0;

   always #4 clock = ~clock;

   min_tracking_stack_unit #(.STACK_DEPTH(STACK_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   min_tracking_stack_checker #(.STACK_DEPTH(STACK_DEPTH)) stack_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // Receiver: stall at the phase's rate; once asked, hold off for a long
   // stretch so the block backs up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Mix small values (so duplicates of the minimum are common), the
   // extremes and fully random words.
   function automatic logic signed [WORD_W-1:0] pick_stack_value();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 4)
         return int'($urandom_range(16)) - 8;
      if (pick == 4) begin
         case ($urandom_range(4))
            0: return INT_MAX;
            1: return INT_MIN;
            2: return 0;
            3: return -1;
            default: return 1;
         endcase
      end
      return $urandom;
   endfunction

   // Offer one request after a random idle gap; hold it until accepted.
   task automatic send_request(input logic [1:0] command, input logic signed [WORD_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data.command <= command;
      req_data.value   <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic push_value(input logic signed [WORD_W-1:0] value);
      send_request(CMD_PUSH, value);
   endtask

   // Random mix weighted toward pushes so the stack grows and shrinks.
   task automatic send_mixed(input int unsigned count);
      int unsigned roll;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 52)
            push_value(pick_stack_value());
         else if (roll < 88)
            send_request(CMD_POP, $urandom);
         else if (roll < 97)
            send_request(CMD_PEEK, $urandom);
         else
            send_request(CMD_UNUSED, $urandom);
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty stack, extremes, duplicate minima, unused code.
      send_request(CMD_PEEK, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_UNUSED, $urandom);
      push_value(5);
      push_value(7);
      push_value(5);
      push_value(INT_MAX);
      push_value(INT_MIN);
      push_value(INT_MIN);
      send_request(CMD_PEEK, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_UNUSED, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_POP, $urandom);
      push_value(-1);
      push_value(0);
      push_value(INT_MAX);
      send_request(CMD_POP, $urandom);
      send_request(CMD_POP, $urandom);
      send_request(CMD_POP, $urandom);

      // Random rounds: no idling, sender idle, receiver stalling, both.
      for (int round = 0; round < 4; round++) begin
         case (round)
            0: begin sender_idle_pct = 0;  stall_pct <= 0;  end
            1: begin sender_idle_pct = 87; stall_pct <= 0;  end
            2: begin sender_idle_pct = 0;  stall_pct <= 87; end
            default: begin sender_idle_pct = 10; stall_pct <= 10; end
         endcase
         // request the long receiver hold-off while requests keep coming
         if (round == 0)
            hold_request <= 1'b1;
         send_mixed(60);
         // fill past the top so refused pushes show up
         repeat (70) push_value(pick_stack_value());
         send_mixed(60);
         // drain past the bottom so refused pops show up
         repeat (70) send_request(CMD_POP, $urandom);
         send_mixed(70);
      end
      req_valid <= 1'b0;

      // let the pending count catch up with the last request
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### min_tracking_stack_unit.f
design/mts_pkg.sv
design/mts_ram.sv
design/min_tracking_stack_unit.sv
design/mts_checker.sv
test/min_tracking_stack_checker.sv
test/testbench.sv
